### sv/tcwr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcwr_pkg
// Shared types and codes for the typed column read-modify-write unit.
// ----------------------------------------------------------------------------
package tcwr_pkg;

  localparam int KIND_W   = 3;
  localparam int ROW_W    = 10;
  localparam int DATA_W   = 64;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int ROW_EXT_W  = 17;

  localparam logic [KIND_W-1:0] KIND_WRITE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SUM   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MIN   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MAX   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ROW    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ACCESS = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ELEM_TYPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCESS    = 2'd2;

  localparam logic [1:0] ELEM_TYPE_RST = 2'd2;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } ctrl_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic exec;
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clear_last;
  } dp_stat_t;

endpackage

### sv/typed_column_write_reduce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// typed_column_write_reduce
// Flow: memory read on the accept of a start transfer, combine and write back
// in the execute state, result strobe registered from the execute state. A new
// item is taken only once the unit is idle again. The receiver cannot stall.
// Reset: after rst_n the column is cleared one row a cycle, busy held high;
// configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module typed_column_write_reduce #(
  parameter int ROWS = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [tcwr_pkg::KIND_W-1:0]         in_kind,
  input  logic [tcwr_pkg::ROW_W-1:0]          in_row,
  input  logic [tcwr_pkg::DATA_W-1:0]         in_value,
  output logic                                out_valid,
  output logic [tcwr_pkg::STATUS_W-1:0]       out_status,
  output logic [tcwr_pkg::DATA_W-1:0]         out_read_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tcwr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcwr_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tcwr_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  tcwr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  tcwr_dp #(
    .ROWS (ROWS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_kind       (in_kind),
    .in_row        (in_row),
    .in_value      (in_value),
    .cfg_we        (cfg_valid & cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_status    (out_status),
    .out_read_data (out_read_data)
  );

endmodule

### sv/tcwr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcwr_ctrl
// Sequencer: clearing pass after reset, then accept and execute one item.
// ----------------------------------------------------------------------------
module tcwr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  tcwr_pkg::dp_stat_t  stat,
  output tcwr_pkg::ctrl_cmd_t cmd,
  output logic                busy,
  output logic                out_valid
);
  import tcwr_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        strobe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= cmd.exec;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd.clear  = 1'b0;
    cmd.accept = 1'b0;
    cmd.exec   = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = strobe_r;

endmodule

### sv/tcwr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcwr_dp
// Column memory, configuration registers and the typed combine unit.
// ----------------------------------------------------------------------------
module tcwr_dp #(
  parameter int ROWS = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tcwr_pkg::ctrl_cmd_t                 cmd,
  output tcwr_pkg::dp_stat_t                  stat,
  input  logic [tcwr_pkg::KIND_W-1:0]         in_kind,
  input  logic [tcwr_pkg::ROW_W-1:0]          in_row,
  input  logic [tcwr_pkg::DATA_W-1:0]         in_value,
  input  logic                                cfg_we,
  input  logic [tcwr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcwr_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic [tcwr_pkg::STATUS_W-1:0]       out_status,
  output logic [tcwr_pkg::DATA_W-1:0]         out_read_data
);
  import tcwr_pkg::*;

  localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [DATA_W-1:0] mem [ROWS];

  // configuration
  logic [1:0]            elem_type_r;
  logic [CFG_DATA_W-1:0] row_count_r;
  logic [1:0]            access_r;

  // clearing pass
  logic [AW-1:0] clr_cnt_r;

  // latched item
  logic [KIND_W-1:0] kind_r;
  logic [ROW_W-1:0]  row_r;
  logic [DATA_W-1:0] value_r;
  logic [DATA_W-1:0] rd_data_r;

  logic [STATUS_W-1:0] status_r;
  logic [DATA_W-1:0]   res_data_r;

  logic [ROW_EXT_W-1:0] in_row_ext, row_ext;
  logic [AW-1:0]        in_addr, item_addr, wr_addr;
  logic                 narrow, is_signed, row_bad, wr_en;
  logic [DATA_W-1:0]    cur, inc, sbm, kc, ki, sum, new_val, wr_data;
  logic [STATUS_W-1:0]  status;

  assign in_row_ext = ROW_EXT_W'(in_row);
  assign row_ext    = ROW_EXT_W'(row_r);
  assign in_addr    = in_row_ext[AW-1:0];
  assign item_addr  = row_ext[AW-1:0];

  assign stat.clear_last = (clr_cnt_r == AW'(ROWS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_type_r <= ELEM_TYPE_RST;
      row_count_r <= '0;
      access_r    <= '0;
      clr_cnt_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ELEM_TYPE: elem_type_r <= cfg_data[1:0];
          CFG_ROW_COUNT: row_count_r <= cfg_data;
          CFG_ACCESS:    access_r    <= cfg_data[1:0];
          default:       ;
        endcase
      end
      if (cmd.clear) clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // Item registers and results
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r  <= in_kind;
      row_r   <= in_row;
      value_r <= in_value;
    end
    if (cmd.exec) begin
      status_r   <= status;
      res_data_r <= (status == STATUS_OK) ? new_val : '0;
    end
  end

  // Single-port style memory: registered read on accept, one write per cycle
  assign wr_addr = cmd.clear ? clr_cnt_r : item_addr;
  assign wr_data = cmd.clear ? '0 : new_val;

  always_ff @(posedge clk) begin
    if (cmd.clear || (cmd.exec && wr_en)) mem[wr_addr] <= wr_data;
    if (cmd.accept) rd_data_r <= mem[in_addr];
  end

  // Typed combine
  assign narrow    = ~elem_type_r[1];
  assign is_signed = elem_type_r[0];
  assign cur = narrow ? {32'd0, rd_data_r[31:0]} : rd_data_r;
  assign inc = narrow ? {32'd0, value_r[31:0]} : value_r;
  assign sbm = !is_signed ? '0 : (narrow ? 64'h0000_0000_8000_0000
                                         : 64'h8000_0000_0000_0000);
  assign kc  = cur ^ sbm;
  assign ki  = inc ^ sbm;
  assign sum = narrow ? {32'd0, cur[31:0] + inc[31:0]} : cur + inc;

  assign row_bad = (row_ext >= ROW_EXT_W'(row_count_r)) ||
                   (row_ext >= ROW_EXT_W'(ROWS));

  always_comb begin
    status  = STATUS_OK;
    new_val = cur;
    wr_en   = 1'b0;
    if (row_bad) begin
      status = STATUS_ROW;
    end else begin
      case (kind_r)
        KIND_READ: ;
        KIND_WRITE: begin
          if (access_r[0]) begin
            new_val = inc;
            wr_en   = 1'b1;
          end else begin
            status = STATUS_ACCESS;
          end
        end
        KIND_SUM, KIND_MIN, KIND_MAX: begin
          if (access_r[1]) begin
            wr_en = 1'b1;
            if (kind_r == KIND_SUM)      new_val = sum;
            else if (kind_r == KIND_MIN) new_val = (ki < kc) ? inc : cur;
            else                         new_val = (ki > kc) ? inc : cur;
          end else begin
            status = STATUS_ACCESS;
          end
        end
        default: status = STATUS_ACCESS;
      endcase
    end
  end

  assign out_status    = status_r;
  assign out_read_data = res_data_r;

endmodule

### test/typed_column_write_reduce_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// typed_column_write_reduce_tb
// Self-checking bench for the typed column read-modify-write unit. A driver
// feeds write, sum, min, max and read commands from a queue under random
// start gaps. A behavioural copy of the column predicts status and data for
// each transfer, and the monitor compares every strobed result in order.
// Settings are changed between phases, once all results have been drained.
// ----------------------------------------------------------------------------
module typed_column_write_reduce_tb;
  import tcwr_pkg::*;

  localparam int NUM_ROWS = 1024;

  // element type codes and access bits of the configuration registers
  localparam logic [1:0] TYPE_U32 = 2'd0;
  localparam logic [1:0] TYPE_I32 = 2'd1;
  localparam logic [1:0] TYPE_U64 = 2'd2;
  localparam logic [1:0] TYPE_I64 = 2'd3;
  localparam logic [1:0] ACC_NONE   = 2'b00;
  localparam logic [1:0] ACC_WRITE  = 2'b01;
  localparam logic [1:0] ACC_REDUCE = 2'b10;
  localparam logic [1:0] ACC_ALL    = 2'b11;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [KIND_W-1:0] KIND_BAD_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_BAD_HI = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ROW_W-1:0]  row;
    logic [DATA_W-1:0] value;
  } col_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   data;
  } col_res_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [KIND_W-1:0]     in_kind = '0;
  logic [ROW_W-1:0]      in_row = '0;
  logic [DATA_W-1:0]     in_value = '0;
  logic                  out_valid;
  logic [STATUS_W-1:0]   out_status;
  logic [DATA_W-1:0]     out_read_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // shadow of the column and its settings
  logic [DATA_W-1:0]     col_model [NUM_ROWS];
  logic [1:0]            sh_type;
  logic [CFG_DATA_W-1:0] sh_rows;
  logic [1:0]            sh_access;

  col_op_t  op_queue[$];
  col_res_t column_results_q[$];
  bit       calm = 1'b0;
  int       n_sent = 0;
  int       n_checked = 0;
  int       n_phases = 0;
  int       mismatches = 0;

  typed_column_write_reduce #(
    .ROWS(NUM_ROWS)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_kind      (in_kind),
    .in_row       (in_row),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_read_data(out_read_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #1ms;
    $display("status: fail");
    $finish;
  end

  task automatic flag_mismatch(string msg);
    if (mismatches < 40) $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Apply one command to the shadow column and return its result
  function automatic col_res_t apply_column_op(col_op_t op);
    col_res_t         res;
    logic             narrow;
    logic             signd;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] sbit;
    logic [DATA_W-1:0] cur;
    logic [DATA_W-1:0] inc;
    logic [DATA_W-1:0] key_cur;
    logic [DATA_W-1:0] key_inc;
    narrow = (sh_type == TYPE_U32) || (sh_type == TYPE_I32);
    signd  = (sh_type == TYPE_I32) || (sh_type == TYPE_I64);
    mask   = narrow ? 64'h0000_0000_FFFF_FFFF : '1;
    sbit   = !signd ? '0 : (narrow ? 64'h0000_0000_8000_0000 : 64'h8000_0000_0000_0000);
    res.status = STATUS_OK;
    res.data   = '0;
    if ({1'b0, op.row} >= sh_rows) begin
      res.status = STATUS_ROW;
      return res;
    end
    cur = col_model[op.row] & mask;
    inc = op.value & mask;
    case (op.kind)
      KIND_READ: begin
        res.data = cur;
        return res;
      end
      KIND_WRITE: begin
        if ((sh_access & ACC_WRITE) == ACC_NONE) begin
          res.status = STATUS_ACCESS;
          return res;
        end
        cur = inc;
      end
      KIND_SUM, KIND_MIN, KIND_MAX: begin
        if ((sh_access & ACC_REDUCE) == ACC_NONE) begin
          res.status = STATUS_ACCESS;
          return res;
        end
        // flip the sign bit so signed order becomes unsigned order
        key_cur = (cur ^ sbit) & mask;
        key_inc = (inc ^ sbit) & mask;
        if (op.kind == KIND_SUM) cur = (cur + inc) & mask;
        else if (op.kind == KIND_MIN) cur = (key_inc < key_cur) ? inc : cur;
        else cur = (key_inc > key_cur) ? inc : cur;
      end
      default: begin
        res.status = STATUS_ACCESS;
        return res;
      end
    endcase
    col_model[op.row] = cur;
    res.data = cur;
    return res;
  endfunction

  // Driver: advance on a start transfer, hold while busy
  always @(posedge clk) begin : drive_ops
    col_op_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        column_results_q.push_back(apply_column_op({in_kind, in_row, in_value}));
        n_sent++;
      end
      if (!start || !busy) begin
        if (op_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 7)) begin
          nxt = op_queue.pop_front();
          start    <= 1'b1;
          in_kind  <= nxt.kind;
          in_row   <= nxt.row;
          in_value <= nxt.value;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe is one result transfer
  always @(posedge clk) begin : check_results
    col_res_t want;
    if (rst_n && out_valid) begin
      if (column_results_q.size() == 0) begin
        flag_mismatch($sformatf("result with nothing pending, status %0d data %h",
                                out_status, out_read_data));
      end else begin
        want = column_results_q.pop_front();
        n_checked++;
        if (out_status !== want.status)
          flag_mismatch($sformatf("status %0d, predicted %0d", out_status, want.status));
        if (out_read_data !== want.data)
          flag_mismatch($sformatf("read_data %h, predicted %h", out_read_data, want.data));
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ELEM_TYPE: sh_type   = data[1:0];
      CFG_ROW_COUNT: sh_rows   = data;
      CFG_ACCESS:    sh_access = data[1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic push_op(logic [KIND_W-1:0] kind, logic [ROW_W-1:0] row,
                         logic [DATA_W-1:0] value);
    op_queue.push_back('{kind: kind, row: row, value: value});
  endtask

  // Wait for every queued command and its result, then settle
  task automatic drain();
    @(negedge clk);
    while (op_queue.size() != 0 || start || column_results_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
    n_phases++;
  endtask

  function automatic logic [KIND_W-1:0] pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return KIND_W'($urandom_range(KIND_BAD_LO, KIND_BAD_HI));
    if (r < 30) return KIND_WRITE;
    if (r < 50) return KIND_SUM;
    if (r < 65) return KIND_MIN;
    if (r < 80) return KIND_MAX;
    return KIND_READ;
  endfunction

  // Favour a few low and a few top live rows so read-modify-writes stack up
  function automatic logic [ROW_W-1:0] pick_row(int live);
    int r;
    r = $urandom_range(0, 99);
    if (live == 0 || r < 15) return ROW_W'($urandom_range(0, NUM_ROWS - 1));
    if (r < 55) return ROW_W'($urandom_range(0, (live < 8 ? live : 8) - 1));
    if (r < 75) return ROW_W'($urandom_range(live > 8 ? live - 8 : 0, live - 1));
    return ROW_W'($urandom_range(0, live - 1));
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'h7FFF_FFFF_FFFF_FFFF;
      3: return 64'h8000_0000_0000_0000;
      4: return {32'($urandom), 32'h7FFF_FFFF};
      5: return {32'($urandom), 32'h8000_0000};
      6: return {32'($urandom), 32'($urandom_range(0, 15))};
      default: return {32'($urandom), 32'($urandom)};
    endcase
  endfunction

  initial begin : stimulus
    int rc;
    int live;
    int n_ops;
    for (int i = 0; i < NUM_ROWS; i++) col_model[i] = '0;
    sh_type   = ELEM_TYPE_RST;
    sh_rows   = '0;
    sh_access = ACC_NONE;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: no live rows
    push_op(KIND_READ, 10'd0, '0);
    push_op(KIND_WRITE, 10'd5, '1);
    drain();

    // all rows live, nothing allowed, type still at its reset value
    write_reg(CFG_ROW_COUNT, 11'd1024);
    write_reg(CFG_UNUSED, '1);
    push_op(KIND_WRITE, 10'd0, '1);
    push_op(KIND_SUM, 10'd0, 64'd1);
    push_op(KIND_READ, 10'd1023, '0);
    push_op(KIND_BAD_LO, 10'd3, '0);
    drain();

    write_reg(CFG_ACCESS, {9'h1FF, ACC_ALL});
    push_op(KIND_WRITE, 10'd0, '1);
    push_op(KIND_SUM, 10'd0, 64'd1);
    push_op(KIND_WRITE, 10'd1, 64'h8000_0000_0000_0000);
    push_op(KIND_MAX, 10'd1, 64'd1);
    push_op(KIND_MIN, 10'd1, 64'd1);
    push_op(KIND_WRITE, 10'd1023, 64'h7FFF_FFFF_FFFF_FFFF);
    push_op(KIND_READ, 10'd1023, '0);
    push_op(KIND_BAD_HI, 10'd2, '1);
    drain();

    // signed 64-bit, reductions only, four live rows: row check wins
    write_reg(CFG_ELEM_TYPE, {9'h155, TYPE_I64});
    write_reg(CFG_ROW_COUNT, 11'd4);
    write_reg(CFG_ACCESS, {9'h0AA, ACC_REDUCE});
    push_op(KIND_WRITE, 10'd0, 64'd7);
    push_op(KIND_SUM, 10'd9, 64'd7);
    push_op(KIND_MAX, 10'd1, 64'd5);
    push_op(KIND_MIN, 10'd1, 64'h8000_0000_0000_0000);
    push_op(KIND_SUM, 10'd1, 64'h8000_0000_0000_0000);
    push_op(KIND_BAD_LO + 3'd1, 10'd200, '0);
    drain();

    // narrow types: zero extension, wrap and signed order at 32 bits
    write_reg(CFG_ELEM_TYPE, {9'h0, TYPE_I32});
    write_reg(CFG_ROW_COUNT, 11'd2047);
    write_reg(CFG_ACCESS, {9'h0, ACC_ALL});
    push_op(KIND_WRITE, 10'd10, 64'hFFFF_FFFF_7FFF_FFFF);
    push_op(KIND_SUM, 10'd10, 64'd1);
    push_op(KIND_MIN, 10'd10, 64'h1234_5678_0000_0005);
    push_op(KIND_MAX, 10'd10, 64'h0000_0000_FFFF_FFFF);
    drain();
    write_reg(CFG_ELEM_TYPE, {9'h0, TYPE_U32});
    push_op(KIND_MAX, 10'd10, 64'd5);
    push_op(KIND_SUM, 10'd10, 64'd1);
    drain();
    write_reg(CFG_ELEM_TYPE, {9'h0, TYPE_U64});
    push_op(KIND_READ, 10'd10, '0);
    drain();

    // random phases across all types and a spread of row counts
    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 5)
        0: rc = 1;
        1: rc = 1024;
        2: rc = 2047;
        3: rc = $urandom_range(2, 64);
        default: rc = $urandom_range(65, 1023);
      endcase
      live  = rc > NUM_ROWS ? NUM_ROWS : rc;
      calm  = (ph == 6);
      write_reg(CFG_ELEM_TYPE, {9'($urandom), 2'(ph % 4)});
      write_reg(CFG_ROW_COUNT, 11'(rc));
      write_reg(CFG_ACCESS,
                {9'($urandom), (ph % 3 == 2) ? 2'($urandom_range(0, 3)) : ACC_ALL});
      if (ph == 4) write_reg(CFG_UNUSED, 11'($urandom));
      n_ops = 140 + $urandom_range(0, 10);
      for (int k = 0; k < n_ops; k++) push_op(pick_kind(), pick_row(live), pick_value());
      drain();
    end
    calm = 1'b0;

    repeat (10) @(posedge clk);
    $display("Covered %0d commands over %0d setting phases, all element types and access modes",
             n_sent, n_phases);
    $display("Checked %0d results, %0d mismatches", n_checked, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
